@@ hdl/walr_pkg.sv @@
// Shared types, constants and helpers for the weekly alarm light ramp.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package walr_pkg;

  // Calendar and alarm word layout.
  localparam int DAYS            = 7;
  localparam int DAY_W           = 3;
  localparam logic [DAY_W-1:0] WEEKDAY_UNKNOWN = 3'd7;
  localparam logic [DAY_W-1:0] IDX_SUNDAY      = 3'd6;
  localparam int HOUR_W          = 5;
  localparam int MIN_W           = 6;
  localparam int SEC_W           = 6;
  localparam int WORD_W          = 20;
  localparam int EN_BIT          = 0;
  localparam int HOUR_LSB        = 1;
  localparam int MIN_LSB         = 6;
  localparam int DUR_LSB         = 12;

  // Duration field: only the low DURATION_BITS bits are used, never more than the word holds.
  localparam int DURATION_BITS   = 8;
  localparam int DUR_FIELD_W     = WORD_W - DUR_LSB;
  localparam int DUR_W = (DURATION_BITS < DUR_FIELD_W) ? DURATION_BITS : DUR_FIELD_W;

  // Countdown and ramp arithmetic.
  localparam int COUNT_W         = 14;
  localparam int SEC_PER_MIN     = 60;
  localparam int PROD_W          = DUR_W + 6;
  localparam int SAT_W           = (PROD_W > COUNT_W) ? PROD_W : COUNT_W;
  localparam logic [SAT_W-1:0] COUNT_MAX = SAT_W'((1 << COUNT_W) - 1);
  localparam int FULL_SCALE      = 100;
  localparam int LEVEL_W         = 7;
  localparam int NUM_W           = 22;
  localparam int DEN_W           = COUNT_W + 1;
  localparam int QUOT_W          = LEVEL_W;
  localparam int STEP_W          = $clog2(QUOT_W);

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EVAL,
    ST_PREP,
    ST_START,
    ST_DIV,
    ST_DONE
  } walr_state_t;

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Calendar day (Sunday first) to alarm slot (Monday first).
  function automatic logic [DAY_W-1:0] day_index(input logic [DAY_W-1:0] wday);
    logic [DAY_W-1:0] idx;
    if (wday == '0) begin
      idx = IDX_SUNDAY;
    end else begin
      idx = wday - DAY_W'(1);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

@@ hdl/walr_regs.sv @@
// Alarm word register file: seven per-day words behind the configuration write port.
// Depends on walr_pkg.
`default_nettype none

module walr_regs
  import walr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [DAY_W-1:0]  cfg_index,
  input  wire logic [WORD_W-1:0] cfg_data,
  input  wire logic [DAY_W-1:0]  day_sel,
  output logic      [WORD_W-1:0] word
);

  logic [WORD_W-1:0] alarm_word [DAYS];

  // Writes are always taken; indexes past the last day are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DAYS; i++) begin
        alarm_word[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready && (cfg_index < DAY_W'(DAYS))) begin
      alarm_word[cfg_index] <= cfg_data;
    end
  end

  // Word of the selected day slot.
  always_comb begin
    if (day_sel < DAY_W'(DAYS)) begin
      word = alarm_word[day_sel];
    end else begin
      word = '0;
    end
  end

endmodule

`default_nettype wire

@@ hdl/walr_div.sv @@
// Restoring divider, one quotient bit per cycle, for the ramp level.
// Depends on walr_pkg. The quotient must fit in QUOT_W bits.
`default_nettype none

module walr_div
  import walr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [NUM_W-1:0]  num,
  input  wire logic [DEN_W-1:0]  den,
  output div_stat_t              stat,
  output logic      [QUOT_W-1:0] quot
);

  localparam int SH_W = DEN_W + QUOT_W - 1;

  logic [NUM_W-1:0]  rem;
  logic [SH_W-1:0]   dsh;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;
  logic              fits;

  // Trial subtraction of the shifted divisor.
  assign fits = rem >= NUM_W'(dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(QUOT_W - 1);
        rem  <= num;
        dsh  <= SH_W'(den) << (QUOT_W - 1);
        quot <= '0;
      end else if (busy) begin
        if (fits) begin
          rem <= rem - NUM_W'(dsh);
        end
        quot <= {quot[QUOT_W-2:0], fits};
        dsh  <= dsh >> 1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - STEP_W'(1);
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

@@ hdl/weekly_alarm_light_ramp_top.sv @@
// Top level of the weekly alarm light ramp: sequencer, alarm state and result register.
// Depends on walr_pkg, walr_regs and walr_div.
//
// Usage:
//   One request per wall-clock tick enters on in_valid/in_stall with weekday, hour,
//   minute and second. Every request gives exactly one result on out_valid/out_stall.
//   Alarm words are written through cfg_valid/cfg_ready with cfg_index 0 (Monday)
//   to 6 (Sunday); cfg_ready is always high and larger indexes are ignored.
//   Write the words only while no request is in flight.
// Sequence:
//   An accepted tick goes through LOOK and EVAL. A tick that does no ramp step then
//   goes to DONE, a ramp step with zero duration passes PREP on to DONE, and a ramp
//   step that divides passes PREP, START and DIV, where the restoring divider gives one
//   quotient bit per cycle, then DONE. The block takes one request at a time: in_stall
//   is high from acceptance until the result is loaded into the output register, and
//   the next request can be taken in the cycle after that.
// Reset and stall:
//   rst (synchronous) clears all alarm words, ends any running alarm and drops
//   out_valid. A held result waits in the output register while out_stall is high;
//   a finished request behind it waits in the sequencer until the register frees.
`default_nettype none

module weekly_alarm_light_ramp_top
  import walr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [DAY_W-1:0]   weekday,
  input  wire logic [HOUR_W-1:0]  hour,
  input  wire logic [MIN_W-1:0]   minute,
  input  wire logic [SEC_W-1:0]   second,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [DAY_W-1:0]   cfg_index,
  input  wire logic [WORD_W-1:0]  cfg_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    light_update,
  output logic      [LEVEL_W-1:0] intensity,
  output logic                    alarm_begins,
  output logic                    alarm_ends,
  output logic                    alarm_running
);

  walr_state_t        state;
  walr_state_t        state_next;

  // Captured tick.
  logic [DAY_W-1:0]   tick_day;
  logic [HOUR_W-1:0]  tick_hour;
  logic [MIN_W-1:0]   tick_min;
  logic [SEC_W-1:0]   tick_sec;

  // Alarm state.
  logic               running;
  logic [COUNT_W-1:0] remaining_seconds;
  logic [COUNT_W-1:0] total_seconds;

  // Per-request working values.
  logic [WORD_W-1:0]  sel_word;
  logic [WORD_W-1:0]  rd_word;
  logic               step_r;
  logic               begins_r;
  logic               ends_r;
  logic [LEVEL_W-1:0] level_r;
  logic [NUM_W-1:0]   num_r;
  logic [DEN_W-1:0]   den_r;

  // Sequencer controls.
  logic               accept;
  logic               div_start;
  logic               out_load;
  div_stat_t          div_stat;
  logic [QUOT_W-1:0]  div_quot;

  // Decoded alarm word and start decision.
  logic               known_day;
  logic               start_hit;
  logic [DUR_W-1:0]   dur;
  logic [SAT_W-1:0]   secs_full;
  logic [COUNT_W-1:0] secs;

  walr_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .day_sel   (day_index(tick_day)),
    .word      (rd_word)
  );

  walr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  // Start condition and countdown length from the selected word.
  always_comb begin
    known_day = tick_day != WEEKDAY_UNKNOWN;
    start_hit = known_day && sel_word[EN_BIT] &&
                (sel_word[HOUR_LSB +: HOUR_W] == tick_hour) &&
                (sel_word[MIN_LSB +: MIN_W] == tick_min) &&
                (tick_sec[SEC_W-1:1] == '0) && !running;
    dur       = sel_word[DUR_LSB +: DUR_W];
    secs_full = SAT_W'(dur) * SAT_W'(SEC_PER_MIN);
    if (secs_full > COUNT_MAX) begin
      secs = COUNT_MAX[COUNT_W-1:0];
    end else begin
      secs = secs_full[COUNT_W-1:0];
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (known_day && (running || start_hit)) begin
          state_next = ST_PREP;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_PREP: begin
        if (total_seconds == '0) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall  = state != ST_IDLE;
    div_start = state == ST_START;
    out_load  = (state == ST_DONE) && (!out_valid || !out_stall);
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Tick capture and word lookup.
  always_ff @(posedge clk) begin
    if (accept) begin
      tick_day  <= weekday;
      tick_hour <= hour;
      tick_min  <= minute;
      tick_sec  <= second;
    end
    if (state == ST_LOOK) begin
      sel_word <= rd_word;
    end
  end

  // Alarm state: start in EVAL, count down in PREP.
  always_ff @(posedge clk) begin
    if (rst) begin
      running           <= 1'b0;
      remaining_seconds <= '0;
      total_seconds     <= '0;
    end else if ((state == ST_EVAL) && start_hit) begin
      running           <= 1'b1;
      remaining_seconds <= secs;
      total_seconds     <= secs;
    end else if (state == ST_PREP) begin
      if (remaining_seconds == '0) begin
        running           <= 1'b0;
        remaining_seconds <= '0;
        total_seconds     <= '0;
      end else begin
        remaining_seconds <= remaining_seconds - COUNT_W'(1);
      end
    end
  end

  // Result flags, divider operands and ramp level.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_EVAL: begin
        step_r   <= known_day && (running || start_hit);
        begins_r <= start_hit;
        ends_r   <= 1'b0;
        level_r  <= '0;
      end
      ST_PREP: begin
        ends_r <= remaining_seconds == '0;
        num_r  <= NUM_W'(total_seconds - remaining_seconds) * NUM_W'(2 * FULL_SCALE) +
                  NUM_W'(total_seconds);
        den_r  <= {total_seconds, 1'b0};
        if (total_seconds == '0) begin
          level_r <= LEVEL_W'(FULL_SCALE);
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          level_r <= div_quot;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register; a held result stays until the receiver drops stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      light_update  <= step_r;
      intensity     <= level_r;
      alarm_begins  <= begins_r;
      alarm_ends    <= ends_r;
      alarm_running <= running;
    end
  end

`ifndef NO_ASSERTIONS
  // The countdown never exceeds its own starting length.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    remaining_seconds <= total_seconds)
    else $error("remaining seconds above total seconds");

  // Any delivered level is a percentage.
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (intensity <= LEVEL_W'(FULL_SCALE)))
    else $error("intensity above full scale");

  // Starting or ending an alarm always comes with a ramp step.
  a_flags_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (alarm_begins || alarm_ends)) |-> light_update)
    else $error("alarm event without a ramp step");

  // No new request is taken while the divider works.
  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (in_stall && (state == ST_DIV)))
    else $error("divider busy outside its wait state");

  // A finished request cannot overwrite a result still held by the receiver.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(intensity) && $stable(alarm_running)))
    else $error("held result changed");
`endif

endmodule

`default_nettype wire

@@ tb/sv/walr_checker.sv @@
// Checker for the weekly alarm light ramp: watches the tick, config and result channels,
// predicts every result from its own copy of the alarm words and ramp state, and compares.
// Depends on walr_pkg for field widths and the alarm word layout.
module walr_checker
  import walr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [DAY_W-1:0]   weekday,
  input  logic [HOUR_W-1:0]  hour,
  input  logic [MIN_W-1:0]   minute,
  input  logic [SEC_W-1:0]   second,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [DAY_W-1:0]   cfg_index,
  input  logic [WORD_W-1:0]  cfg_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               light_update,
  input  logic [LEVEL_W-1:0] intensity,
  input  logic               alarm_begins,
  input  logic               alarm_ends,
  input  logic               alarm_running,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COUNT_LIMIT = (1 << COUNT_W) - 1;

  typedef struct packed {
    logic               light_update;
    logic [LEVEL_W-1:0] intensity;
    logic               alarm_begins;
    logic               alarm_ends;
    logic               alarm_running;
  } tick_result_t;

  // Predicted alarm words and ramp state.
  logic [WORD_W-1:0]  alarm_words [DAYS];
  logic               ramp_active;
  logic [COUNT_W-1:0] secs_left;
  logic [COUNT_W-1:0] secs_total;
  tick_result_t       expected_results [$];

  // Percent of the ramp done, rounded with halves up; a zero-length ramp is fully lit.
  function automatic int ramp_percent(input int left, input int total);
    if (total == 0) begin
      return FULL_SCALE;
    end
    if (left > total) begin
      left = total;
    end
    return (2 * FULL_SCALE * (total - left) + total) / (2 * total);
  endfunction

  // Advance the predicted alarm state by one tick and queue the result it gives.
  task automatic predict_tick(input logic [DAY_W-1:0] wd, input logic [HOUR_W-1:0] hh,
                              input logic [MIN_W-1:0] mm, input logic [SEC_W-1:0] ss);
    tick_result_t      res;
    logic [WORD_W-1:0] word;
    int                slot;
    int                dur;
    int                secs;
    res = '0;
    if (wd != WEEKDAY_UNKNOWN) begin
      // Sunday-first calendar day to Monday-first alarm slot.
      slot = (int'(wd) + DAYS - 1) % DAYS;
      word = alarm_words[slot];
      dur  = int'(word >> DUR_LSB) & ((1 << DUR_W) - 1);
      if (word[EN_BIT] && word[HOUR_LSB +: HOUR_W] == hh && word[MIN_LSB +: MIN_W] == mm &&
          (ss == 0 || ss == 1) && !ramp_active) begin
        secs = dur * SEC_PER_MIN;
        if (secs > COUNT_LIMIT) begin
          secs = COUNT_LIMIT;
        end
        ramp_active      = 1'b1;
        secs_total       = COUNT_W'(secs);
        secs_left        = COUNT_W'(secs);
        res.alarm_begins = 1'b1;
      end
      if (ramp_active) begin
        res.light_update = 1'b1;
        res.intensity    = LEVEL_W'(ramp_percent(int'(secs_left), int'(secs_total)));
        if (secs_left == '0) begin
          ramp_active    = 1'b0;
          secs_total     = '0;
          res.alarm_ends = 1'b1;
        end else begin
          secs_left = secs_left - 1'b1;
        end
      end
    end
    res.alarm_running = ramp_active;
    expected_results.push_back(res);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Results are checked before new requests are predicted, so a same-edge request
  // always lands behind the result it cannot have caused.
  always @(posedge clk) begin : monitor
    tick_result_t want;
    if (rst) begin
      foreach (alarm_words[i]) begin
        alarm_words[i] = '0;
      end
      ramp_active = 1'b0;
      secs_left   = '0;
      secs_total  = '0;
      fail_count  = 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no request waiting: light_update %0d intensity %0d",
                 light_update, intensity);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("light_update", want.light_update, light_update);
          check_field("intensity", want.intensity, intensity);
          check_field("alarm_begins", want.alarm_begins, alarm_begins);
          check_field("alarm_ends", want.alarm_ends, alarm_ends);
          check_field("alarm_running", want.alarm_running, alarm_running);
        end
      end
      // Indexes past the last weekday are dropped by the block.
      if (cfg_valid && cfg_ready && int'(cfg_index) < DAYS) begin
        alarm_words[cfg_index] = cfg_data;
      end
      if (in_valid && !in_stall) begin
        predict_tick(weekday, hour, minute, second);
      end
    end
    pending = expected_results.size();
  end

endmodule

@@ tb/sv/tb_weekly_alarm_light_ramp_top.sv @@
// Testbench top for the weekly alarm light ramp: clock, reset, tick and alarm word stimulus,
// random output stalls, a watchdog and the final verdict.
// Depends on walr_pkg, weekly_alarm_light_ramp_top and walr_checker.
module tb_weekly_alarm_light_ramp_top;
  timeunit 1ns;
  timeprecision 1ps;
  import walr_pkg::*;

  localparam int PHASES           = 7;
  localparam int TICKS_PER_PHASE  = 100;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int HOLD_AFTER_TICKS = 250;
  localparam int DRAIN_CYCLES     = 20;
  localparam int MAX_DURATION     = (1 << DUR_W) - 1;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [DAY_W-1:0]   weekday;
  logic [HOUR_W-1:0]  hour;
  logic [MIN_W-1:0]   minute;
  logic [SEC_W-1:0]   second;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [DAY_W-1:0]   cfg_index;
  logic [WORD_W-1:0]  cfg_data;
  logic               out_valid;
  logic               out_stall;
  logic               light_update;
  logic [LEVEL_W-1:0] intensity;
  logic               alarm_begins;
  logic               alarm_ends;
  logic               alarm_running;
  int                 fail_count;
  int                 pending;

  // Stimulus-side state: the words being loaded, a running wall clock and pacing flags.
  logic [WORD_W-1:0]  alarm_plan [DAYS];
  int                 clk_day  = 1;
  int                 clk_hour = 6;
  int                 clk_min  = 30;
  int                 clk_sec  = 3;
  int                 ticks_sent = 0;
  bit                 calm_sender = 1'b1;
  bit                 hold_done = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  weekly_alarm_light_ramp_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .weekday       (weekday),
    .hour          (hour),
    .minute        (minute),
    .second        (second),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .light_update  (light_update),
    .intensity     (intensity),
    .alarm_begins  (alarm_begins),
    .alarm_ends    (alarm_ends),
    .alarm_running (alarm_running)
  );

  walr_checker checker_inst (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .weekday       (weekday),
    .hour          (hour),
    .minute        (minute),
    .second        (second),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .light_update  (light_update),
    .intensity     (intensity),
    .alarm_begins  (alarm_begins),
    .alarm_ends    (alarm_ends),
    .alarm_running (alarm_running),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  function automatic logic [WORD_W-1:0] pack_alarm(input int en, input int hh, input int mm,
                                                   input int dur);
    return {DUR_FIELD_W'(dur), MIN_W'(mm), HOUR_W'(hh), 1'(en)};
  endfunction

  // Mostly enabled alarms at real times with short ramps, now and then all zeros or all ones.
  function automatic logic [WORD_W-1:0] random_alarm(input int max_dur);
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      return '0;
    end
    if (pick == 1) begin
      return '1;
    end
    return pack_alarm(($urandom_range(0, 7) != 0), $urandom_range(0, 23), $urandom_range(0, 59),
                      (pick < 5) ? $urandom_range(0, max_dur) : $urandom_range(0, 1));
  endfunction

  // Offer one tick request, hold it until accepted, then leave a random gap.
  task automatic offer_tick(input int wd, input int hh, input int mm, input int ss);
    int gap;
    int pick;
    in_valid = 1'b1;
    weekday  = DAY_W'(wd);
    hour     = HOUR_W'(hh);
    minute   = MIN_W'(mm);
    second   = SEC_W'(ss);
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    @(negedge clk);
    ticks_sent++;
    gap  = 0;
    pick = $urandom_range(0, 99);
    if (!calm_sender) begin
      if (pick >= 95) begin
        gap = $urandom_range(10, 40);
      end else if (pick >= 70) begin
        gap = $urandom_range(1, 3);
      end
    end
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Stop offering and wait until every predicted result has come out.
  task automatic quiesce();
    in_valid = 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (2) @(negedge clk);
  endtask

  // Write all seven alarm words, optionally followed by a write to an unused index.
  task automatic load_alarms(input bit with_stray);
    int last;
    last = with_stray ? DAYS : DAYS - 1;
    for (int idx = 0; idx <= last; idx++) begin
      cfg_valid = 1'b1;
      cfg_index = DAY_W'(idx);
      cfg_data  = (idx < DAYS) ? alarm_plan[idx] : WORD_W'($urandom);
      @(posedge clk);
      while (!cfg_ready) begin
        @(posedge clk);
      end
      @(negedge clk);
    end
    cfg_valid = 1'b0;
  endtask

  // Pick the next tick: mostly the wall clock stepping one second, sometimes a jump
  // onto a programmed alarm time, a jump anywhere, or raw noise over the full field range.
  task automatic next_tick(output int wd, output int hh, output int mm, output int ss);
    int pick;
    int day;
    bit moved;
    pick  = $urandom_range(0, 99);
    moved = 1'b0;
    if (pick < 10) begin
      wd = $urandom_range(0, 7);
      hh = $urandom_range(0, 31);
      mm = $urandom_range(0, 63);
      ss = $urandom_range(0, 63);
      return;
    end
    if (pick < 25) begin
      day = $urandom_range(0, DAYS - 1);
      if (alarm_plan[day][HOUR_LSB +: HOUR_W] <= 23 && alarm_plan[day][MIN_LSB +: MIN_W] <= 59) begin
        clk_day  = (day + 1) % DAYS;
        clk_hour = int'(alarm_plan[day][HOUR_LSB +: HOUR_W]);
        clk_min  = int'(alarm_plan[day][MIN_LSB +: MIN_W]);
        clk_sec  = $urandom_range(0, 3);
        moved    = 1'b1;
      end
    end else if (pick < 30) begin
      clk_day  = $urandom_range(0, DAYS - 1);
      clk_hour = $urandom_range(0, 23);
      clk_min  = $urandom_range(0, 59);
      clk_sec  = $urandom_range(0, 59);
      moved    = 1'b1;
    end
    if (!moved) begin
      if (clk_sec == 59 && $urandom_range(0, 15) == 0) begin
        clk_sec = 60;
      end else if (clk_sec >= 59) begin
        clk_sec = 0;
        clk_min++;
        if (clk_min >= 60) begin
          clk_min = 0;
          clk_hour++;
          if (clk_hour >= 24) begin
            clk_hour = 0;
            clk_day  = (clk_day + 1) % DAYS;
          end
        end
      end else begin
        clk_sec++;
      end
    end
    wd = clk_day;
    hh = clk_hour;
    mm = clk_min;
    ss = clk_sec;
  endtask

  // Output side: random stall segments, plus one long hold-off once the run is under way.
  initial begin : receiver
    int len;
    bit stall_now;
    out_stall = 1'b0;
    forever begin
      if (!hold_done && ticks_sent >= HOLD_AFTER_TICKS) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      stall_now = ($urandom_range(0, 2) == 0);
      if (stall_now) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 6);
      end
      out_stall = stall_now;
      repeat (len) @(negedge clk);
    end
  end

  // End the run if no request moves on any channel for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int wd;
    int hh;
    int mm;
    int ss;
    int live;
    rst       = 1'b1;
    in_valid  = 1'b0;
    weekday   = '0;
    hour      = '0;
    minute    = '0;
    second    = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // All words are zero after reset, so these ticks must not start anything.
    offer_tick(1, 0, 0, 0);
    offer_tick(0, 0, 0, 1);

    // Directed alarm set: a one-minute ramp, a zero-length ramp, an all-ones word,
    // a disabled word, and alarms at the ends of the day.
    alarm_plan[0] = pack_alarm(1, 6, 30, 1);
    alarm_plan[1] = pack_alarm(1, 7, 0, 0);
    alarm_plan[2] = '1;
    alarm_plan[3] = pack_alarm(0, 5, 10, 1);
    alarm_plan[4] = pack_alarm(1, 23, 59, 2);
    alarm_plan[5] = pack_alarm(1, 0, 0, 1);
    alarm_plan[6] = pack_alarm(1, 12, 15, 3);
    quiesce();
    load_alarms(1'b1);

    offer_tick(WEEKDAY_UNKNOWN, 6, 30, 0);   // unknown weekday at the Monday time
    offer_tick(4, 5, 10, 0);                 // disabled Thursday word
    offer_tick(3, 31, 63, 63);               // time fields at their top values, Wednesday
    offer_tick(0, 0, 0, 0);                  // every field at zero, Sunday
    offer_tick(6, 0, 0, 2);                  // Saturday time but too late in the minute
    offer_tick(2, 7, 0, 1);                  // zero duration starts and ends at once
    offer_tick(1, 6, 30, 0);                 // Monday ramp starts
    offer_tick(1, 6, 30, 1);                 // matching again while running
    offer_tick(WEEKDAY_UNKNOWN, 6, 30, 2);   // unknown weekday while running
    offer_tick(1, 6, 30, 60);                // leap second
    offer_tick(2, 7, 0, 0);                  // another alarm's time while running

    // Random phases, each with its own alarm words; the last one uses the longest ramp.
    for (int phase = 0; phase < PHASES; phase++) begin
      calm_sender = (phase % 3 == 0);
      for (int d = 0; d < DAYS; d++) begin
        alarm_plan[d] = (phase == PHASES - 1) ?
                        pack_alarm(1, $urandom_range(0, 23), $urandom_range(0, 59), MAX_DURATION) :
                        random_alarm(3);
      end
      quiesce();
      load_alarms(phase == 2);
      live = 0;
      while (live < TICKS_PER_PHASE) begin
        next_tick(wd, hh, mm, ss);
        offer_tick(wd, hh, mm, ss);
        if (wd != WEEKDAY_UNKNOWN) begin
          live++;
        end
        // One pause in mid-phase until the block has drained.
        if (phase == 1 && live == TICKS_PER_PHASE / 2) begin
          quiesce();
        end
      end
    end

    quiesce();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/walr_pkg.sv
hdl/walr_regs.sv
hdl/walr_div.sv
hdl/weekly_alarm_light_ramp_top.sv
tb/sv/walr_checker.sv
tb/sv/tb_weekly_alarm_light_ramp_top.sv
